// File: rtl/hc3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_pkg
// Types, constants and mod-26 arithmetic shared by the 3x3 Hill cipher
// stream core and its transform pipeline.
// ----------------------------------------------------------------------------
package hc3_pkg;

  localparam int GROUP_LEN = 3;
  localparam int MAX_GAP   = 8;
  // a gap never holds more than eight spaces, so one item yields at most 19 results
  localparam logic [3:0] GAP_LIMIT = 4'((MAX_GAP < 8) ? MAX_GAP : 8);

  localparam int KEY_W   = 45;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MATRIX   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 1'b1;

  // identity key: ones at (0,0), (1,1), (2,2)
  localparam logic [KEY_W-1:0] KEY_RESET = 45'h100_0010_0001;

  localparam logic [4:0] PAD_LETTER = 5'd23;   // X
  localparam logic [4:0] ALPHA      = 5'd26;

  typedef struct packed {
    logic [4:0] letter;
    logic       is_space;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       out_space;
    logic       last_of_text;
    logic       last_of_burst;
    logic       key_error;
    logic       gap_overflow;
  } out_item_t;

  // one emission: a lone space, or up to three letters with two gaps
  typedef struct packed {
    logic [2:0][4:0] lt;
    logic [1:0]      cnt;
    logic [1:0][3:0] gap;
    logic            lone;
    logic            eot;
    logic            ovf;
    logic            kerr;
  } burst_t;

  // emission request into the transform pipeline
  typedef struct packed {
    burst_t           b;
    logic             xform;
    logic [KEY_W-1:0] key;
    logic             decrypt;
  } grp_t;

  typedef enum logic [1:0] {
    SEQ_LETTER,
    SEQ_GAP,
    SEQ_LONE
  } seq_phase_t;

  // reduce a 5-bit value into 0..25
  function automatic logic [4:0] mod26_5(input logic [4:0] x);
    return (x >= ALPHA) ? (x - ALPHA) : x;
  endfunction

  // x mod 26 for x below 2048: reciprocal estimate, then one correction
  function automatic logic [4:0] mod26_w(input logic [10:0] x);
    logic [20:0] p;
    logic [10:0] q;
    logic [10:0] r;
    p = 21'(x) * 21'd630;
    q = 11'(p >> 14);
    r = x - 11'(q * 11'd26);
    if (r >= 11'd26) begin
      r = r - 11'd26;
    end
    return r[4:0];
  endfunction

  function automatic logic [9:0] mul5(input logic [4:0] a, input logic [4:0] b);
    return 10'(a) * 10'(b);
  endfunction

  // sum of three products of residues, mod 26
  function automatic logic [4:0] dot3_mod26(input logic [2:0][4:0] a,
                                           input logic [2:0][4:0] b);
    logic [10:0] s;
    s = 11'(mul5(a[0], b[0])) + 11'(mul5(a[1], b[1])) + 11'(mul5(a[2], b[2]));
    return mod26_w(s);
  endfunction

  // (a*b - c*d) mod 26; 676 = 26*26 keeps the difference positive
  function automatic logic [4:0] cof_mod26(input logic [4:0] a, input logic [4:0] b,
                                          input logic [4:0] c, input logic [4:0] d);
    logic [10:0] s;
    s = 11'(mul5(a, b)) + 11'd676 - 11'(mul5(c, d));
    return mod26_w(s);
  endfunction

  // inverse mod 26; zero where the residue has none
  function automatic logic [4:0] inv26(input logic [4:0] x);
    logic [4:0] r;
    case (x)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/hc3_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_xform
// Four-stage pipeline that turns an emission request into its final letters:
// cofactors and encrypt product, then determinant inverse and adjugate
// product, then scaling, then an output register.
// ----------------------------------------------------------------------------
module hc3_xform
  import hc3_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   req_valid,
  input  grp_t   req,
  output logic   req_stall,
  output logic   rsp_valid,
  output burst_t rsp,
  input  logic   rsp_stall
);

  // stage valids and load enables
  logic s1_v_r, s2_v_r, s3_v_r, o_v_r;
  logic s1_ld, s2_ld, s3_ld, o_ld;

  grp_t                 s1_r;
  burst_t               s2_b_r;
  logic                 s2_xform_r, s2_dec_r;
  logic [2:0][4:0]      s2_k0_r;
  logic [2:0][2:0][4:0] s2_cof_r;
  logic [2:0][4:0]      s2_e_r;
  burst_t               s3_b_r;
  logic                 s3_xform_r, s3_dec_r, s3_bad_r;
  logic [4:0]           s3_dinv_r;
  logic [2:0][4:0]      s3_u_r;
  logic [2:0][4:0]      s3_e_r;
  burst_t               o_r;

  logic [2:0][2:0][4:0] s1_k;
  logic [2:0][2:0][4:0] s1_cof;
  logic [2:0][4:0]      s1_e;
  logic [4:0]           s2_dinv;
  logic                 s2_bad;
  logic [2:0][4:0]      s2_u;
  burst_t               s3_res;

  // move a stage when the next one is empty or moving
  assign o_ld  = !o_v_r || !rsp_stall;
  assign s3_ld = !s3_v_r || o_ld;
  assign s2_ld = !s2_v_r || s3_ld;
  assign s1_ld = !s1_v_r || s2_ld;
  assign req_stall = !s1_ld;
  assign rsp_valid = o_v_r;
  assign rsp       = o_r;

  // stage 1: reduce key, cofactors, encrypt product
  always_comb begin
    logic [2:0][4:0] kcol;
    int r1, r2, c1, c2;
    kcol = '0;
    r1 = 0; r2 = 0; c1 = 0; c2 = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s1_k[r][c] = mod26_5(s1_r.key[5*(3*r+c) +: 5]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      r1 = (r == 2) ? 0 : r + 1;
      r2 = (r == 0) ? 2 : r - 1;
      for (int c = 0; c < 3; c++) begin
        c1 = (c == 2) ? 0 : c + 1;
        c2 = (c == 0) ? 2 : c - 1;
        s1_cof[r][c] = cof_mod26(s1_k[r1][c1], s1_k[r2][c2], s1_k[r1][c2], s1_k[r2][c1]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        kcol[r] = s1_k[r][c];
      end
      s1_e[c] = dot3_mod26(s1_r.b.lt, kcol);
    end
  end

  // stage 2: determinant inverse and product with the adjugate
  always_comb begin
    s2_dinv = inv26(dot3_mod26(s2_k0_r, s2_cof_r[0]));
    s2_bad  = s2_dec_r && (s2_dinv == 5'd0);
    for (int c = 0; c < 3; c++) begin
      s2_u[c] = dot3_mod26(s2_b_r.lt, s2_cof_r[c]);
    end
  end

  // stage 3: pick the result letters
  always_comb begin
    s3_res      = s3_b_r;
    s3_res.kerr = s3_bad_r;
    for (int c = 0; c < 3; c++) begin
      if (!s3_xform_r || (s3_dec_r && s3_bad_r)) begin
        s3_res.lt[c] = s3_b_r.lt[c];
      end else if (!s3_dec_r) begin
        s3_res.lt[c] = s3_e_r[c];
      end else begin
        s3_res.lt[c] = mod26_w(11'(mul5(s3_dinv_r, s3_u_r[c])));
      end
    end
  end

  // valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_ld) s1_v_r <= req_valid;
      if (s2_ld) s2_v_r <= s1_v_r;
      if (s3_ld) s3_v_r <= s2_v_r;
      if (o_ld)  o_v_r  <= s3_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_r <= req;
    end
    if (s2_ld) begin
      s2_b_r     <= s1_r.b;
      s2_xform_r <= s1_r.xform;
      s2_dec_r   <= s1_r.decrypt;
      s2_k0_r    <= s1_k[0];
      s2_cof_r   <= s1_cof;
      s2_e_r     <= s1_e;
    end
    if (s3_ld) begin
      s3_b_r     <= s2_b_r;
      s3_xform_r <= s2_xform_r;
      s3_dec_r   <= s2_dec_r;
      s3_bad_r   <= s2_bad;
      s3_dinv_r  <= s2_dinv;
      s3_u_r     <= s2_u;
      s3_e_r     <= s2_e_r;
    end
    if (o_ld) begin
      o_r <= s3_res;
    end
  end

endmodule

// File: rtl/hill_cipher_3x3_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_stream_core
// Streaming 3x3 Hill cipher mod 26 with space pass-through, gap buffering,
// end-of-text padding and decrypt by modular inverse of the key.
// ----------------------------------------------------------------------------
// Path: an accepted item's first result passes the input register, three pipeline
//   registers and then the burst register before it is offered.
// Throughput: one item per cycle while in_stall is low; one result per cycle while
//   out_stall is low; an item with n results holds the output until all n go out.
// Reset: group state, gaps and overflow flag clear; key returns to identity,
//   mode to encrypt; no result is pending.
module hill_cipher_3x3_stream_core
  import hc3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata
);

  // configuration and latched working key
  logic [KEY_W-1:0] key_r;
  logic             mode_r;
  logic [KEY_W-1:0] wkey_r;
  logic             wmode_r;

  // group state
  logic [1:0][4:0] held_r, held_nxt;
  logic [1:0]      held_count_r, held_count_nxt;
  logic [1:0][3:0] gap_r, gap_nxt;
  logic            ovf_seen_r, ovf_seen_nxt;

  logic   in_fire, out_fire;
  logic   emit;
  grp_t   grp;
  logic   req_stall;
  logic   rsp_valid, rsp_stall;
  burst_t rsp;

  // burst sequencer
  logic       b_v_r, b_v_nxt;
  burst_t     b_r, b_nxt;
  seq_phase_t phase_r, phase_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [3:0] gl_r, gl_nxt;
  logic       is_last, b_ld;

  assign in_stall = req_stall;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // step: update group state and form the emission of this item
  always_comb begin
    logic [4:0] letter_m;
    logic       hc0, gsel, wm;
    letter_m = mod26_5(in_data.letter);
    hc0      = (held_count_r == 2'd0);
    gsel     = held_count_r[1];
    wm       = hc0 ? mode_r : wmode_r;

    held_nxt       = held_r;
    held_count_nxt = held_count_r;
    gap_nxt        = gap_r;
    ovf_seen_nxt   = ovf_seen_r;
    emit           = 1'b0;
    grp            = '0;

    if (in_data.is_space) begin
      if (hc0) begin
        emit        = 1'b1;
        grp.b.lone  = 1'b1;
      end else if (gap_r[gsel] < GAP_LIMIT) begin
        gap_nxt[gsel] = gap_r[gsel] + 4'd1;
      end else begin
        ovf_seen_nxt = 1'b1;
      end
    end else if (held_count_r == 2'd2) begin
      // third letter completes the group
      emit          = 1'b1;
      grp.b.lt[0]   = held_r[0];
      grp.b.lt[1]   = held_r[1];
      grp.b.lt[2]   = letter_m;
      grp.b.cnt     = 2'd3;
      grp.b.gap     = gap_r;
      grp.b.ovf     = ovf_seen_r;
      grp.xform     = 1'b1;
      held_count_nxt = 2'd0;
      gap_nxt        = '0;
      ovf_seen_nxt   = 1'b0;
    end else begin
      held_nxt[held_count_r[0]] = letter_m;
      held_count_nxt            = held_count_r + 2'd1;
    end

    // flush a partial group at end of text
    if (in_data.end_of_text && (held_count_nxt != 2'd0)) begin
      emit        = 1'b1;
      grp.b.lone  = 1'b0;
      grp.b.lt[0] = held_nxt[0];
      grp.b.lt[1] = (held_count_nxt == 2'd2) ? held_nxt[1] : PAD_LETTER;
      grp.b.lt[2] = PAD_LETTER;
      grp.b.gap   = gap_nxt;
      grp.b.ovf   = ovf_seen_nxt;
      if (wm) begin
        grp.b.cnt = held_count_nxt;
        grp.xform = 1'b0;
      end else begin
        grp.b.cnt = 2'd3;
        grp.xform = 1'b1;
      end
    end
    if (in_data.end_of_text) begin
      held_count_nxt = 2'd0;
      gap_nxt        = '0;
      ovf_seen_nxt   = 1'b0;
    end

    grp.b.eot   = in_data.end_of_text;
    grp.key     = hc0 ? key_r : wkey_r;
    grp.decrypt = wm;
  end

  hc3_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_fire && emit),
    .req       (grp),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= KEY_RESET;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_MATRIX:   key_r  <= cfg_wdata;
        CFG_DECRYPT_MODE: mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // group state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 2'd0;
      gap_r        <= '0;
      ovf_seen_r   <= 1'b0;
    end else if (in_fire) begin
      held_count_r <= held_count_nxt;
      gap_r        <= gap_nxt;
      ovf_seen_r   <= ovf_seen_nxt;
    end
  end

  // held letters and working key; latch the key at the start of each group
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r <= held_nxt;
      if (held_count_r == 2'd0) begin
        wkey_r  <= key_r;
        wmode_r <= mode_r;
      end
    end
  end

  // gap that follows letter idx of a burst
  function automatic logic [3:0] gap_r_sel(input burst_t b, input logic [1:0] idx);
    return b.gap[idx[0]];
  endfunction

  // sequencer: current result and next position
  always_comb begin
    logic last_letter;
    last_letter = ((3'(idx_r) + 3'd1) >= 3'(b_r.cnt));
    case (phase_r)
      SEQ_LONE:   is_last = 1'b1;
      SEQ_LETTER: is_last = ((idx_r == 2'd2) || (gap_r_sel(b_r, idx_r) == 4'd0)) && last_letter;
      SEQ_GAP:    is_last = (gl_r == 4'd1) && last_letter;
      default:    is_last = 1'b1;
    endcase

    out_valid              = b_v_r;
    out_data.out_letter    = (phase_r == SEQ_LETTER) ? b_r.lt[idx_r] : 5'd0;
    out_data.out_space     = (phase_r != SEQ_LETTER);
    out_data.last_of_text  = b_r.eot && is_last;
    out_data.last_of_burst = is_last;
    out_data.key_error     = b_r.kerr;
    out_data.gap_overflow  = b_r.ovf;

    b_ld      = !b_v_r || (out_fire && is_last);
    rsp_stall = !b_ld;

    b_v_nxt   = b_v_r;
    b_nxt     = b_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    gl_nxt    = gl_r;
    if (b_ld) begin
      // take the next burst
      b_v_nxt = rsp_valid;
      if (rsp_valid) begin
        b_nxt     = rsp;
        phase_nxt = rsp.lone ? SEQ_LONE : SEQ_LETTER;
        idx_nxt   = 2'd0;
        gl_nxt    = 4'd0;
      end
    end else if (out_fire) begin
      // advance within the burst
      case (phase_r)
        SEQ_LETTER: begin
          if ((idx_r != 2'd2) && (gap_r_sel(b_r, idx_r) != 4'd0)) begin
            phase_nxt = SEQ_GAP;
            gl_nxt    = gap_r_sel(b_r, idx_r);
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        SEQ_GAP: begin
          if (gl_r > 4'd1) begin
            gl_nxt = gl_r - 4'd1;
          end else begin
            phase_nxt = SEQ_LETTER;
            idx_nxt   = idx_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      phase_r <= SEQ_LETTER;
      idx_r   <= 2'd0;
      gl_r    <= 4'd0;
    end else begin
      b_v_r   <= b_v_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      gl_r    <= gl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt;
  end

  // end of text leaves no partial group behind
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_text) |=>
      (held_count_r == 2'd0 && gap_r == '0 && !ovf_seen_r))
    else $error("group state not cleared after end of text");

  // a space result carries letter zero
  a_space_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_space) |-> (out_data.out_letter == 5'd0))
    else $error("space result with nonzero letter");

  // end of text is only flagged on the last result of a burst
  a_text_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_of_text) |-> out_data.last_of_burst)
    else $error("last_of_text without last_of_burst");

  // flags hold across the results of one burst
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_data.last_of_burst) |=>
      (out_valid && out_data.key_error == $past(out_data.key_error) &&
       out_data.gap_overflow == $past(out_data.gap_overflow)))
    else $error("burst flags changed within a burst");

endmodule
